// ===== hdl/assert_macros.svh =====
// Assertion helpers. Both sample on the rising edge of clock and are
// switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define GBYI_ASSERT_IMP(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("assertion failed");

// Implication checked on the following edge.
`define GBYI_ASSERT_NXT(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

// ===== hdl/gbyi_pkg.sv =====
package gbyi_pkg;

   localparam int RATE_W     = 17;
   localparam int TIME_W     = 32;
   localparam int GAP_W      = 16;
   localparam int THR_W      = 16;
   localparam int CNT_W      = 10;
   localparam int YAW_W      = 26;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // rate with eight extra fraction bits, and differences of two of those
   localparam int X_W    = RATE_W + 8;
   localparam int U_W    = X_W + 1;
   localparam int N_W    = CNT_W + 1;
   localparam int PROD_W = U_W + GAP_W + 1;
   localparam int STEP_W = PROD_W - 8;
   localparam int V_W    = 36;

   localparam int DIV_STEPS  = U_W;
   localparam int WRAP_SHIFT = 9;
   localparam int WRAP_STEPS = WRAP_SHIFT + 1;
   localparam int SEQ_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [THR_W-1:0] STILL_THR_RST  = THR_W'(128);
   localparam logic [CNT_W-1:0] LOCK_COUNT_RST = CNT_W'(400);
   localparam logic [GAP_W-1:0] MAX_GAP_RST    = GAP_W'(200);

   localparam longint YAW_MOD  = 64'd46080000;
   localparam longint YAW_HALF = 64'd23040000;
   // offset keeps the pre-wrap sum positive for any step size
   localparam longint WRAP_BIAS = YAW_HALF + (YAW_MOD << WRAP_SHIFT);

   localparam logic signed [YAW_W-1:0] YAW_LO = -YAW_W'(YAW_HALF);
   localparam logic signed [YAW_W-1:0] YAW_HI = YAW_W'(YAW_HALF);

   localparam logic signed [RATE_W+1:0] RATE_MAX = (RATE_W+2)'(65535);
   localparam logic signed [RATE_W+1:0] RATE_MIN = -(RATE_W+2)'(65536);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STILL_THRESHOLD = 2'd0,
      CSR_LOCK_COUNT      = 2'd1,
      CSR_MAX_GAP_MS      = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_BIAS,
      ST_CALC_U,
      ST_MUL,
      ST_SUM,
      ST_WRAP,
      ST_FIN,
      ST_OUT
   } gbyi_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CHECK,
      OP_DIV,
      OP_BIAS,
      OP_CALC_U,
      OP_MUL,
      OP_SUM,
      OP_WRAP,
      OP_FIN
   } gbyi_op_type;

   typedef struct packed {
      logic        capture;
      gbyi_op_type op;
      logic        load_rsp;
   } gbyi_cmd_type;

   typedef struct packed {
      logic sample_ok;
      logic still_update;
   } gbyi_status_type;

endpackage

// ===== hdl/gbyi_dp.sv =====
`include "assert_macros.svh"

module gbyi_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  gbyi_pkg::gbyi_cmd_type                 cmd,
   output gbyi_pkg::gbyi_status_type              status,
   input  logic                                   csr_valid,
   input  logic [gbyi_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [gbyi_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic signed [gbyi_pkg::RATE_W-1:0]     req_gyro_rate,
   input  logic [gbyi_pkg::TIME_W-1:0]            req_time_ms,
   output logic                                   rsp_accepted,
   output logic signed [gbyi_pkg::YAW_W-1:0]      rsp_yaw_angle,
   output logic signed [gbyi_pkg::RATE_W-1:0]     rsp_yaw_rate,
   output logic                                   rsp_bias_locked
);
   import gbyi_pkg::*;

   // configuration
   logic [THR_W-1:0] thr_ff;
   logic [CNT_W-1:0] lock_cnt_ff;
   logic [GAP_W-1:0] max_gap_ff;

   // architectural state
   logic [TIME_W-1:0]       last_time_ff;
   logic signed [X_W-1:0]   bias_ff;
   logic [CNT_W-1:0]        samples_ff;
   logic                    locked_ff;
   logic signed [YAW_W-1:0] yaw_ff;
   logic signed [RATE_W-1:0] last_rate_ff;

   // working registers
   logic signed [RATE_W-1:0] rate_ff;
   logic [TIME_W-1:0]        time_ff;
   logic [GAP_W-1:0]         gap_ff;
   logic                     ok_ff;
   logic [U_W-1:0]           quot_ff;
   logic [N_W-1:0]           rem_ff;
   logic [N_W-1:0]           n_ff;
   logic                     neg_ff;
   logic signed [U_W-1:0]    u_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [V_W-1:0]           v_ff;
   logic [V_W-1:0]           sub_ff;

   logic signed [X_W-1:0]    x;
   logic [TIME_W-1:0]        gap_full;
   logic                     sample_ok;
   logic [RATE_W-1:0]        mag;
   logic                     still;
   logic signed [U_W-1:0]    d;
   logic [U_W-1:0]           d_mag;
   logic [N_W:0]             rem_sh;
   logic                     rem_ge;
   logic [N_W:0]             rem_diff;
   logic signed [U_W-1:0]    q_signed;
   logic signed [U_W-1:0]    bias_sum;
   logic [CNT_W-1:0]         samples_nx;
   logic signed [RATE_W+9:0] rate_rnd;
   logic signed [RATE_W+1:0] rate_div;
   logic signed [RATE_W-1:0] rate_sat;
   logic signed [PROD_W-1:0] prod_c;
   logic signed [PROD_W-1:0] prod_rnd;
   logic signed [STEP_W-1:0] step;
   logic signed [V_W:0]      v_sum;
   logic [YAW_W:0]           yaw_nx;

   assign x        = {rate_ff, 8'd0};
   assign gap_full = time_ff - last_time_ff;
   assign sample_ok = (time_ff > last_time_ff) && (gap_full[TIME_W-1:GAP_W] == '0)
                      && (gap_full[GAP_W-1:0] <= max_gap_ff);
   assign mag      = rate_ff[RATE_W-1] ? RATE_W'(-rate_ff) : RATE_W'(rate_ff);
   assign still    = mag < {1'b0, thr_ff};

   assign status.sample_ok    = sample_ok;
   assign status.still_update = sample_ok && !locked_ff && still;

   assign d     = U_W'(x) - U_W'(bias_ff);
   assign d_mag = d[U_W-1] ? U_W'(-d) : U_W'(d);

   // one restoring-division step per cycle
   assign rem_sh   = {rem_ff, quot_ff[U_W-1]};
   assign rem_ge   = rem_sh >= {1'b0, n_ff};
   assign rem_diff = rem_sh - {1'b0, n_ff};

   assign q_signed   = neg_ff ? -$signed(quot_ff) : $signed(quot_ff);
   assign bias_sum   = U_W'(bias_ff) + q_signed;
   assign samples_nx = n_ff[CNT_W-1:0];

   // rate output: round to 1/128 deg/s and saturate
   assign rate_rnd = (RATE_W+10)'(u_ff) + (RATE_W+10)'(128);
   assign rate_div = rate_rnd[RATE_W+9:8];
   always_comb begin
      if (rate_div > RATE_MAX) begin
         rate_sat = RATE_W'(RATE_MAX);
      end else if (rate_div < RATE_MIN) begin
         rate_sat = RATE_W'(RATE_MIN);
      end else begin
         rate_sat = rate_div[RATE_W-1:0];
      end
   end

   assign prod_c   = u_ff * $signed({1'b0, gap_ff});
   assign prod_rnd = prod_ff + PROD_W'(128);
   assign step     = prod_rnd[PROD_W-1:8];
   assign v_sum    = (V_W+1)'(yaw_ff) + (V_W+1)'(step) + (V_W+1)'(WRAP_BIAS);
   assign yaw_nx   = {1'b0, v_ff[YAW_W-1:0]} - (YAW_W+1)'(YAW_HALF);

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= STILL_THR_RST;
         lock_cnt_ff <= LOCK_COUNT_RST;
         max_gap_ff  <= MAX_GAP_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_STILL_THRESHOLD: thr_ff      <= csr_wdata[THR_W-1:0];
            CSR_LOCK_COUNT:      lock_cnt_ff <= csr_wdata[CNT_W-1:0];
            CSR_MAX_GAP_MS:      max_gap_ff  <= csr_wdata[GAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         bias_ff      <= '0;
         samples_ff   <= '0;
         locked_ff    <= 1'b0;
         yaw_ff       <= '0;
         last_rate_ff <= '0;
      end else begin
         case (cmd.op)
            OP_CHECK: begin
               last_time_ff <= time_ff;
               if (sample_ok && !locked_ff && !still) begin
                  bias_ff    <= '0;
                  samples_ff <= '0;
               end
            end
            OP_BIAS: begin
               bias_ff    <= bias_sum[X_W-1:0];
               samples_ff <= samples_nx;
               if (samples_nx >= lock_cnt_ff) begin
                  locked_ff <= 1'b1;
               end
            end
            OP_MUL: last_rate_ff <= rate_sat;
            OP_FIN: yaw_ff <= yaw_nx[YAW_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rate_ff <= req_gyro_rate;
         time_ff <= req_time_ms;
      end
      case (cmd.op)
         OP_CHECK: begin
            ok_ff   <= sample_ok;
            gap_ff  <= gap_full[GAP_W-1:0];
            quot_ff <= d_mag;
            rem_ff  <= '0;
            n_ff    <= N_W'(samples_ff) + N_W'(1);
            neg_ff  <= d[U_W-1];
         end
         OP_DIV: begin
            quot_ff <= {quot_ff[U_W-2:0], rem_ge};
            rem_ff  <= rem_ge ? rem_diff[N_W-1:0] : rem_sh[N_W-1:0];
         end
         OP_CALC_U: u_ff <= d;
         OP_MUL:    prod_ff <= prod_c;
         OP_SUM: begin
            v_ff   <= v_sum[V_W-1:0];
            sub_ff <= V_W'(YAW_MOD) << WRAP_SHIFT;
         end
         OP_WRAP: begin
            if (v_ff >= sub_ff) begin
               v_ff <= v_ff - sub_ff;
            end
            sub_ff <= sub_ff >> 1;
         end
         default: ;
      endcase
      if (cmd.load_rsp) begin
         rsp_accepted    <= ok_ff;
         rsp_yaw_angle   <= yaw_ff;
         rsp_yaw_rate    <= last_rate_ff;
         rsp_bias_locked <= locked_ff;
      end
   end

   `GBYI_ASSERT_NXT(a_div_rem_bound, cmd.op == OP_DIV, rem_ff < n_ff)
   `GBYI_ASSERT_NXT(a_yaw_wrapped, cmd.op == OP_FIN, yaw_ff >= YAW_LO && yaw_ff < YAW_HI)
   `GBYI_ASSERT_IMP(a_lock_sticky, 1'b1, !$fell(locked_ff))

endmodule

// ===== hdl/gbyi_ctrl.sv =====
`include "assert_macros.svh"

module gbyi_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  gbyi_pkg::gbyi_status_type   status,
   output gbyi_pkg::gbyi_cmd_type      cmd
);
   import gbyi_pkg::*;

   localparam logic [SEQ_CNT_W-1:0] DIV_LAST  = SEQ_CNT_W'(DIV_STEPS - 1);
   localparam logic [SEQ_CNT_W-1:0] WRAP_LAST = SEQ_CNT_W'(WRAP_STEPS - 1);

   gbyi_state_type         state_ff, state_in;
   logic [SEQ_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd.capture  = 1'b0;
      cmd.op       = OP_NONE;
      cmd.load_rsp = 1'b0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.op = OP_CHECK;
            cnt_in = '0;
            if (!status.sample_ok) begin
               state_in = ST_OUT;
            end else if (status.still_update) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_CALC_U;
            end
         end
         ST_DIV: begin
            cmd.op = OP_DIV;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_BIAS;
            end
         end
         ST_BIAS: begin
            cmd.op   = OP_BIAS;
            state_in = ST_CALC_U;
         end
         ST_CALC_U: begin
            cmd.op   = OP_CALC_U;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.op   = OP_MUL;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.op   = OP_SUM;
            cnt_in   = '0;
            state_in = ST_WRAP;
         end
         ST_WRAP: begin
            cmd.op = OP_WRAP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == WRAP_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.op   = OP_FIN;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `GBYI_ASSERT_NXT(a_accept_to_check, req_valid && req_ready, state_ff == ST_CHECK)
   `GBYI_ASSERT_NXT(a_div_ends, state_ff == ST_DIV && cnt_ff == DIV_LAST, state_ff == ST_BIAS)
   `GBYI_ASSERT_IMP(a_no_rsp_overwrite, cmd.load_rsp, !rsp_valid_ff || rsp_ready)

endmodule

// ===== hdl/gyro_bias_yaw_integrator.sv =====
// Channel   Handshake              Payload
// req       req_valid/req_ready    req_gyro_rate, req_time_ms
// rsp       rsp_valid/rsp_ready    rsp_accepted, rsp_yaw_angle, rsp_yaw_rate,
//                                  rsp_bias_locked
// csr       csr_valid/csr_ready    csr_index, csr_wdata (always ready)
//
// One item at a time. A rejected item goes from the check state to output;
// an accepted one passes CALC_U, MUL, SUM, WRAP and FIN first, with a serial
// divide for the running mean ahead while the bias is still being learned
// from a still sample. The 10-step heading wrap follows in every accepted item.
// The result sits in an output register, so the next item is taken while it
// waits; a stalled rsp side holds the block only once the next result is due.
// Reset is synchronous and loads the register defaults; no clearing pass.
module gyro_bias_yaw_integrator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [gbyi_pkg::RATE_W-1:0]     req_gyro_rate,
   input  logic [gbyi_pkg::TIME_W-1:0]            req_time_ms,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_accepted,
   output logic signed [gbyi_pkg::YAW_W-1:0]      rsp_yaw_angle,
   output logic signed [gbyi_pkg::RATE_W-1:0]     rsp_yaw_rate,
   output logic                                   rsp_bias_locked,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [gbyi_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [gbyi_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import gbyi_pkg::*;

   gbyi_cmd_type    cmd;
   gbyi_status_type status;

   assign csr_ready = 1'b1;

   gbyi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gbyi_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_gyro_rate   (req_gyro_rate),
      .req_time_ms     (req_time_ms),
      .rsp_accepted    (rsp_accepted),
      .rsp_yaw_angle   (rsp_yaw_angle),
      .rsp_yaw_rate    (rsp_yaw_rate),
      .rsp_bias_locked (rsp_bias_locked)
   );

endmodule
